// ===== rtl/core/sha1md_pkg.sv =====
// Shared types, constants and helper functions of the SHA-1 digest block.
package sha1md_pkg;

   // Round and block geometry
   localparam int ROUNDS       = 80;
   localparam int ROUND_W      = $clog2(ROUNDS);
   localparam int BLOCK_BYTES  = 64;
   localparam int FILL_W       = $clog2(BLOCK_BYTES);
   localparam int DIGEST_WORDS = 5;
   localparam int IDX_W        = 3;

   // Padding constants
   localparam logic [7:0]        PAD_MARK = 8'h80;
   localparam logic [FILL_W-1:0] LEN_POS  = FILL_W'(56);
   localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(BLOCK_BYTES - 1);

   // Initial chaining values H0..H4
   localparam logic [31:0] H_INIT [0:DIGEST_WORDS-1] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // Source of the byte written into the block buffer
   typedef enum logic [1:0] {
      BYTE_REQ  = 2'd0,
      BYTE_MARK = 2'd1,
      BYTE_ZERO = 2'd2,
      BYTE_LEN  = 2'd3
   } byte_sel_type;

   // Round group, selects the mixing function and the round constant
   typedef enum logic [1:0] {
      PH_CHOOSE = 2'd0,
      PH_PARITY1 = 2'd1,
      PH_MAJORITY = 2'd2,
      PH_PARITY2 = 2'd3
   } phase_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                put_en;
      byte_sel_type        byte_sel;
      logic                load_work;
      logic                round_en;
      phase_type           phase;
      logic                fold_en;
      logic                restart;
      logic [IDX_W-1:0]    out_idx;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [FILL_W-1:0] fill;
   } status_type;

   // Round constant of one round group
   function automatic logic [31:0] round_k(phase_type ph);
      logic [31:0] k;
      unique case (ph)
         PH_CHOOSE:   k = 32'h5A827999;
         PH_PARITY1:  k = 32'h6ED9EBA1;
         PH_MAJORITY: k = 32'h8F1BBCDC;
         PH_PARITY2:  k = 32'hCA62C1D6;
         default:     k = 32'h5A827999;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/sha1_message_digest.sv =====
// Top level of the SHA-1 digest block: controller and datapath.
//
// SHA-1 over a byte stream. Each accepted word carries at most one message byte and may
// close the message; on the closing word the block pads the message, finishes the last
// compression and returns the 160-bit digest as five 32-bit words, H0 first, then starts
// over for the next message. The 64th byte of every block starts a compression (80 rounds
// on a single round unit, then a fold into the chaining words), during which req_stall is
// high. Closing a message writes the padding bytes (9 to 72), runs one or two compressions
// and delivers five output words, one per cycle when rsp_stall is low. A new message is
// taken once the fifth word is delivered.
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   cmd_type    cmd;
   status_type status;

   sha1md_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .cmd                (cmd),
      .status             (status)
   );

   sha1md_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

// ===== rtl/core/sha1md_ctrl.sv =====
// Sequencer of the SHA-1 digest block: absorb, padding, rounds, fold and digest output.
module sha1md_ctrl
   import sha1md_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_has_byte,
   input  logic             req_end_of_message,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [IDX_W-1:0] rsp_word_index,
   output logic             rsp_last_word,
   output cmd_type          cmd,
   input  status_type       status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_FOLD,
      ST_OUTPUT
   } state_type;

   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(DIGEST_WORDS - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

   state_type            state_ff, state_in;
   state_type            ret_ff, ret_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 last_slot;

   assign last_slot = (status.fill == LAST_POS);

   // Handshake outputs follow the state
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUTPUT);
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == LAST_IDX);

   // Decode next state and datapath commands
   always_comb begin
      cmd          = '0;
      cmd.byte_sel = BYTE_REQ;
      cmd.phase    = PH_CHOOSE;
      cmd.out_idx  = idx_ff;
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  cmd.put_en   = 1'b1;
                  cmd.byte_sel = BYTE_REQ;
               end
               if (req_has_byte && last_slot) begin
                  cmd.load_work = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
                  ret_in        = req_end_of_message ? ST_PAD_MARK : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end

         ST_PAD_MARK: begin
            cmd.put_en   = 1'b1;
            cmd.byte_sel = BYTE_MARK;
            if (last_slot) begin
               cmd.load_work = 1'b1;
               round_in      = '0;
               state_in      = ST_ROUND;
               ret_in        = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end

         ST_PAD_ZERO: begin
            cmd.put_en = 1'b1;
            if (status.fill == LEN_POS) begin
               // zeros done, start the length field
               cmd.byte_sel = BYTE_LEN;
               state_in     = ST_PAD_LEN;
            end else begin
               cmd.byte_sel = BYTE_ZERO;
               if (last_slot) begin
                  cmd.load_work = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
                  ret_in        = ST_PAD_ZERO;
               end
            end
         end

         ST_PAD_LEN: begin
            cmd.put_en   = 1'b1;
            cmd.byte_sel = BYTE_LEN;
            if (last_slot) begin
               cmd.load_work = 1'b1;
               round_in      = '0;
               state_in      = ST_ROUND;
               ret_in        = ST_OUTPUT;
            end
         end

         ST_ROUND: begin
            cmd.round_en = 1'b1;
            priority if (round_ff < ROUND_W'(20)) begin
               cmd.phase = PH_CHOOSE;
            end else if (round_ff < ROUND_W'(40)) begin
               cmd.phase = PH_PARITY1;
            end else if (round_ff < ROUND_W'(60)) begin
               cmd.phase = PH_MAJORITY;
            end else begin
               cmd.phase = PH_PARITY2;
            end
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end

         ST_FOLD: begin
            cmd.fold_en = 1'b1;
            idx_in      = '0;
            state_in    = ret_ff;
         end

         ST_OUTPUT: begin
            if (!rsp_stall) begin
               if (idx_ff == LAST_IDX) begin
                  cmd.restart = 1'b1;
                  idx_in      = '0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, return state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/core/sha1md_dp.sv =====
// Datapath of the SHA-1 digest block: block shift line, round unit, chaining words, bit count.
module sha1md_dp
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [31:0] rsp_digest_word
);

   localparam int BUF_W = 8 * BLOCK_BYTES;

   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [31:0]       chain_ff [0:DIGEST_WORDS-1];
   logic [63:0]       bit_count_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [7:0]        put_byte;
   logic [2:0]        len_sel;
   logic [31:0]       w0, w2, w8, w13, w_new;
   logic [31:0]       f, t;

   assign status.fill     = fill_ff;
   assign rsp_digest_word = chain_ff[cmd.out_idx];

   // Pick the byte to store: message, pad mark, zero or length byte
   assign len_sel = ~fill_ff[2:0];
   always_comb begin
      unique case (cmd.byte_sel)
         BYTE_REQ:  put_byte = req_data_byte;
         BYTE_MARK: put_byte = PAD_MARK;
         BYTE_ZERO: put_byte = 8'h00;
         BYTE_LEN:  put_byte = bit_count_ff[{len_sel, 3'b000} +: 8];
         default:   put_byte = 8'h00;
      endcase
   end

   // Schedule taps: slot j holds W[r+j]
   assign w0    = buf_ff[BUF_W-1        -: 32];
   assign w2    = buf_ff[BUF_W-1-2*32   -: 32];
   assign w8    = buf_ff[BUF_W-1-8*32   -: 32];
   assign w13   = buf_ff[BUF_W-1-13*32  -: 32];
   assign w_new = {w0[31:0] ^ w2 ^ w8 ^ w13} << 1 |
                  {31'd0, (w0[31] ^ w2[31] ^ w8[31] ^ w13[31])};

   // Mixing function of the current round group
   always_comb begin
      unique case (cmd.phase)
         PH_CHOOSE:   f = (b_ff & c_ff) | (~b_ff & d_ff);
         PH_MAJORITY: f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         PH_PARITY1,
         PH_PARITY2:  f = b_ff ^ c_ff ^ d_ff;
         default:     f = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + round_k(cmd.phase) + w0;

   // Shift a byte in, or advance the schedule by one word
   always_comb begin
      buf_in = buf_ff;
      if (cmd.put_en) begin
         buf_in = {buf_ff[BUF_W-9:0], put_byte};
      end else if (cmd.round_en) begin
         buf_in = {buf_ff[BUF_W-33:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // Load, advance and hold the working variables
   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cmd.round_en) begin
         a_ff <= t;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   // Chaining words, fill position and message length
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= H_INIT[i];
         end
         bit_count_ff <= '0;
         fill_ff      <= '0;
      end else begin
         if (cmd.fold_en) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
            chain_ff[4] <= chain_ff[4] + e_ff;
         end
         if (cmd.put_en) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.put_en && (cmd.byte_sel == BYTE_REQ)) begin
            bit_count_ff <= bit_count_ff + 64'd8;
         end
      end
   end

endmodule
